// ===== rtl/n2w_pkg.sv =====
package n2w_pkg;

    localparam int NUM_W     = 31;
    localparam int CODE_W    = 5;
    localparam int DIGITS    = 10;
    localparam int DIG_IDX_W = 4;
    localparam int STEP_W    = 34;
    localparam int NUM_POS   = 21;
    localparam int POS_W     = 5;
    localparam int GROUPS    = 4;
    localparam int SLOTS     = 5;

    // Reading-order slot holding the lone word for an input of zero.
    localparam logic [POS_W-1:0] ZERO_POS = POS_W'(20);

    localparam logic [CODE_W-1:0] WORD_ZERO    = CODE_W'(0);
    localparam logic [CODE_W-1:0] WORD_TEN     = CODE_W'(10);
    localparam logic [CODE_W-1:0] WORD_TENS_BASE = CODE_W'(18);
    localparam logic [CODE_W-1:0] WORD_HUNDRED = CODE_W'(28);

    typedef struct packed {
        logic                 load;
        logic                 step;
        logic [DIG_IDX_W-1:0] digit_idx;
        logic [POS_W-1:0]     pos;
    } n2w_cmd_t;

    typedef struct packed {
        logic [POS_W-1:0] first_pos;
        logic [POS_W-1:0] next_pos;
        logic             last;
    } n2w_stat_t;

    // j times ten to the power i, evaluated at elaboration.
    function automatic logic [STEP_W-1:0] step_value(input int unsigned i, input int unsigned j);
        longint unsigned v;
        int unsigned     k;
        v = longint'(j);
        for (k = 0; k < i; k++)
        begin
            v = v * 10;
        end
        return STEP_W'(v);
    endfunction

endpackage

// ===== rtl/number_to_word_tokens_top.sv =====
// Spells a non-negative 31-bit integer (bits 30:0 of the input beat; bit 31 is
// ignored) as a run of English word tokens, one output beat per word, with tlast
// on the final word. One number is handled at a time: after the input beat is
// taken, the ten decimal digits are extracted one digit per cycle through a
// compare-and-subtract unit, the first word is then located, and the words
// then leave at one per cycle while the output is ready. A number has 1 to 16
// words, and the next input beat is taken only after its last word has left.
module number_to_word_tokens_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [30:0] number
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [4:0] word_code
    output logic        m_axis_tlast
);
    import n2w_pkg::*;

    n2w_cmd_t          cmd;
    n2w_stat_t         stat;
    logic [CODE_W-1:0] word_code;

    n2w_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    n2w_datapath u_datapath (
        .clk       (clk),
        .number    (s_axis_tdata[NUM_W-1:0]),
        .cmd       (cmd),
        .stat      (stat),
        .word_code (word_code)
    );

    assign m_axis_tdata = {{(8-CODE_W){1'b0}}, word_code};
    assign m_axis_tlast = stat.last;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again right after an accepted number");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while words are still being sent");

    a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready && !m_axis_tvalid)
        else $error("block did not return to idle after the last word");

    a_zero_alone: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[CODE_W-1:0] == WORD_ZERO) |-> m_axis_tlast)
        else $error("Zero word emitted without ending the run");

endmodule

// ===== rtl/n2w_ctrl.sv =====
module n2w_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  n2w_pkg::n2w_stat_t  stat,
    output n2w_pkg::n2w_cmd_t   cmd
);
    import n2w_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CONV = 2'd1;
    localparam logic [1:0] S_FIND = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [DIG_IDX_W-1:0] digit_idx_reg, digit_idx_next;
    logic [POS_W-1:0]     pos_reg, pos_next;

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = (state_reg == S_EMIT);
    assign cmd.load      = (state_reg == S_IDLE) && in_valid;
    assign cmd.step      = (state_reg == S_CONV);
    assign cmd.digit_idx = digit_idx_reg;
    assign cmd.pos       = pos_reg;

    always_comb
    begin
        state_next     = state_reg;
        digit_idx_next = digit_idx_reg;
        pos_next       = pos_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    digit_idx_next = DIG_IDX_W'(DIGITS - 1);
                    state_next     = S_CONV;
                end
            end
            S_CONV:
            begin
                if (digit_idx_reg == '0)
                begin
                    state_next = S_FIND;
                end
                else
                begin
                    digit_idx_next = digit_idx_reg - 1'b1;
                end
            end
            S_FIND:
            begin
                pos_next   = stat.first_pos;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_ready)
                begin
                    if (stat.last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        pos_next = stat.next_pos;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            digit_idx_reg <= '0;
            pos_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            digit_idx_reg <= digit_idx_next;
            pos_reg       <= pos_next;
        end
    end

endmodule

// ===== rtl/n2w_datapath.sv =====
module n2w_datapath (
    input  logic                          clk,
    input  logic [n2w_pkg::NUM_W-1:0]     number,
    input  n2w_pkg::n2w_cmd_t             cmd,
    output n2w_pkg::n2w_stat_t            stat,
    output logic [n2w_pkg::CODE_W-1:0]    word_code
);
    import n2w_pkg::*;

    logic [NUM_W-1:0]  rem_reg, rem_next;
    logic [3:0]        digit_reg [DIGITS];
    logic [3:0]        dig_ext   [DIGITS + 2];
    logic [STEP_W-1:0] step_tbl  [DIGITS][DIGITS];
    logic [STEP_W-1:0] step_row  [DIGITS];
    logic [3:0]        digit_val;
    logic [NUM_POS-1:0] emit;
    logic [CODE_W-1:0]  code_at [NUM_POS];

    genvar gi, gj;
    generate
        for (gi = 0; gi < DIGITS; gi++)
        begin : g_pow
            for (gj = 0; gj < DIGITS; gj++)
            begin : g_mul
                assign step_tbl[gi][gj] = step_value(gi, gj);
            end
        end
    endgenerate

    assign step_row = step_tbl[cmd.digit_idx];

    // One decimal digit per step: the multiples are monotonic, so the highest one
    // that still fits gives the digit.
    always_comb
    begin
        digit_val = '0;
        for (int j = 1; j < DIGITS; j++)
        begin
            if ({{(STEP_W-NUM_W){1'b0}}, rem_reg} >= step_row[j])
            begin
                digit_val = 4'(j);
            end
        end
        rem_next = rem_reg - step_row[digit_val][NUM_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rem_reg <= number;
        end
        else if (cmd.step)
        begin
            rem_reg                  <= rem_next;
            digit_reg[cmd.digit_idx] <= digit_val;
        end
    end

    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            dig_ext[i] = digit_reg[i];
        end
        dig_ext[DIGITS]     = '0;
        dig_ext[DIGITS + 1] = '0;
    end

    // Each group owns five slots in reading order: digit, Hundred, teen, tens
    // or units, units after tens, scale word. Last slot: Zero for a zero input.
    always_comb
    begin
        logic [3:0] h, t, u;
        logic       rest_nz, grp_nz, all_zero;
        int         base;
        all_zero = 1'b1;
        for (int g = 0; g < GROUPS; g++)
        begin
            base    = (GROUPS - 1 - g) * SLOTS;
            h       = dig_ext[3*g + 2];
            t       = dig_ext[3*g + 1];
            u       = dig_ext[3*g];
            rest_nz = (t != 4'd0) || (u != 4'd0);
            grp_nz  = (h != 4'd0) || rest_nz;
            if (grp_nz)
            begin
                all_zero = 1'b0;
            end
            emit[base]       = (h != 4'd0);
            code_at[base]    = {1'b0, h};
            emit[base+1]     = (h != 4'd0);
            code_at[base+1]  = WORD_HUNDRED;
            emit[base+2]     = rest_nz;
            if (t >= 4'd2)
            begin
                code_at[base+2] = WORD_TENS_BASE + {1'b0, t};
            end
            else if (t == 4'd1)
            begin
                code_at[base+2] = WORD_TEN + {1'b0, u};
            end
            else
            begin
                code_at[base+2] = {1'b0, u};
            end
            emit[base+3]     = (t >= 4'd2) && (u != 4'd0);
            code_at[base+3]  = {1'b0, u};
            emit[base+4]     = (g > 0) && grp_nz;
            code_at[base+4]  = WORD_HUNDRED + CODE_W'(g);
        end
        emit[ZERO_POS]    = all_zero;
        code_at[ZERO_POS] = WORD_ZERO;
    end

    always_comb
    begin
        logic found_first, found_next;
        found_first    = 1'b0;
        found_next     = 1'b0;
        stat.first_pos = ZERO_POS;
        stat.next_pos  = ZERO_POS;
        for (int p = 0; p < NUM_POS; p++)
        begin
            if (emit[p] && !found_first)
            begin
                stat.first_pos = POS_W'(p);
                found_first    = 1'b1;
            end
            if (emit[p] && !found_next && (POS_W'(p) > cmd.pos))
            begin
                stat.next_pos = POS_W'(p);
                found_next    = 1'b1;
            end
        end
        stat.last = !found_next;
    end

    assign word_code = code_at[cmd.pos];

endmodule

// ===== test/number_to_word_tokens_top_test.sv =====
`timescale 1ns / 100ps

module number_to_word_tokens_top_test;

    import n2w_pkg::*;

    localparam logic [CODE_W-1:0] WORD_THOUSAND = CODE_W'(29);
    localparam logic [CODE_W-1:0] WORD_MILLION  = CODE_W'(30);
    localparam logic [CODE_W-1:0] WORD_BILLION  = CODE_W'(31);
    localparam int unsigned NUMBER_MAX     = 32'h7FFF_FFFF;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          RANDOM_PER_PHASE = 109;

    typedef struct {
        logic [CODE_W-1:0] code;
        logic              last;
    } word_beat_t;

    class spelling_board;
        word_beat_t        expected_words[$];
        logic [CODE_W-1:0] spelled[$];
        int                mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            mismatches++;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // Words for one three-digit group; a zero group says nothing.
        function void spell_group(int unsigned g);
            int unsigned hundreds;
            int unsigned rest;
            hundreds = g / 100;
            rest = g % 100;
            if (hundreds != 0)
            begin
                spelled.push_back(CODE_W'(hundreds));
                spelled.push_back(WORD_HUNDRED);
            end
            if (rest != 0)
            begin
                if (rest < 20)
                begin
                    spelled.push_back(CODE_W'(rest));
                end
                else
                begin
                    spelled.push_back(WORD_TENS_BASE + CODE_W'(rest / 10));
                    if (rest % 10 != 0)
                        spelled.push_back(CODE_W'(rest % 10));
                end
            end
        endfunction

        function void note_number(logic [31:0] beat);
            int unsigned n;
            int unsigned g;
            word_beat_t  w;
            n = {1'b0, beat[30:0]};
            spelled.delete();
            if (n == 0)
            begin
                spelled.push_back(WORD_ZERO);
            end
            else
            begin
                g = n / 1000000000;
                if (g != 0)
                begin
                    spell_group(g);
                    spelled.push_back(WORD_BILLION);
                end
                g = (n / 1000000) % 1000;
                if (g != 0)
                begin
                    spell_group(g);
                    spelled.push_back(WORD_MILLION);
                end
                g = (n / 1000) % 1000;
                if (g != 0)
                begin
                    spell_group(g);
                    spelled.push_back(WORD_THOUSAND);
                end
                spell_group(n % 1000);
            end
            foreach (spelled[i])
            begin
                w.code = spelled[i];
                w.last = (i == spelled.size() - 1);
                expected_words.push_back(w);
            end
        endfunction

        function void check_word(logic [CODE_W-1:0] code, logic last);
            word_beat_t w;
            if (expected_words.size() == 0)
            begin
                report($sformatf("word %0d with tlast %0b arrived with none expected",
                                 code, last));
                return;
            end
            w = expected_words.pop_front();
            if (code !== w.code)
                report($sformatf("word_code %0d, expected %0d", code, w.code));
            if (last !== w.last)
                report($sformatf("tlast %0b, expected %0b (word %0d)", last, w.last, w.code));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    spelling_board board;
    int            send_idle_pct;
    int            recv_stall_pct;
    int            quiet_cycles;

    number_to_word_tokens_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Inputs are noted before outputs are checked so a beat never races its own words.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                board.note_number(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                board.check_word(m_axis_tdata[CODE_W-1:0], m_axis_tlast);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_number(input logic [31:0] beat);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // Holds the input quiet until every word already owed has come out.
    task automatic drain_words();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
    endtask

    function automatic int unsigned random_group();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return $urandom_range(1, 19);
            2:       return $urandom_range(2, 9) * 10;
            3:       return $urandom_range(1, 9) * 100;
            default: return $urandom_range(1, 999);
        endcase
    endfunction

    // Mixes full-range, small and group-built values so that zero groups,
    // teens and round tens show up far more often than a flat draw gives.
    function automatic logic [31:0] random_number();
        longint unsigned v;
        int unsigned     billions;
        case ($urandom_range(0, 3))
            0:
            begin
                v = $urandom & NUMBER_MAX;
            end
            1:
            begin
                v = $urandom_range(0, 999);
            end
            default:
            begin
                billions = $urandom_range(0, 2);
                v = longint'(random_group()) * 1000000 + random_group() * 1000 + random_group();
                if (billions * 64'd1000000000 + v > NUMBER_MAX)
                    billions = 1;
                v = v + billions * 64'd1000000000;
            end
        endcase
        return {$urandom_range(0, 1) == 1, v[30:0]};
    endfunction

    initial
    begin
        logic [31:0] directed[$];
        board          = new();
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        quiet_cycles   = 0;
        directed = '{32'd0, 32'h8000_0000, 32'd1, 32'd9, 32'd10, 32'd11, 32'd19, 32'd20,
                     32'd21, 32'd99, 32'd100, 32'd101, 32'd110, 32'd119, 32'd999,
                     32'd1000, 32'd1001, 32'd1000000, 32'd1000000000, 32'd2000000000,
                     32'd999999999, 32'd1234567891, 32'h8000_0000 | 32'd100000100,
                     32'd2147483647, 32'hFFFF_FFFF};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_number(directed[i]);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 72; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin send_idle_pct = 25; recv_stall_pct = 25; end
            endcase
            for (int k = 0; k < RANDOM_PER_PHASE; k++)
            begin
                if (phase == 2 && k == RANDOM_PER_PHASE / 2)
                    drain_words();
                send_number(random_number());
            end
            drain_words();
        end

        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (board.mismatches == 0 && board.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/n2w_pkg.sv
rtl/n2w_ctrl.sv
rtl/n2w_datapath.sv
rtl/number_to_word_tokens_top.sv
test/number_to_word_tokens_top_test.sv
